// ===== rtl/tpcr_pkg.sv =====
// shared types, constants and pixel helpers for the text plane cell renderer
package tpcr_pkg;

    // default sizes of the plane and the font
    localparam int GLYPH_COUNT_DEF   = 128;
    localparam int PLANE_COLUMNS_DEF = 32;
    localparam int PLANE_ROWS_DEF    = 16;

    // fixed field widths
    localparam int COL_W      = 5;
    localparam int ROW_W      = 4;
    localparam int BYTE_W     = 8;
    localparam int CODE_W     = 7;
    localparam int GLINE_W    = 3;
    localparam int LINE_W     = 4;
    localparam int PIX_W      = 32;
    localparam int CODE_EXT_W = 9;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    // visible area and text column limit
    localparam int VIS_COL_MIN  = 2;
    localparam int VIS_COL_END  = 29;
    localparam int VIS_ROW_MIN  = 1;
    localparam int TEXT_COL_END = 26;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MODE_CONTROL  = 2'd0,
        REG_COLOR_CONTROL = 2'd1,
        REG_WINDOW_LIMITS = 2'd2,
        REG_TEXT_COLORS   = 2'd3
    } cfg_reg_t;

    // fill modes outside the text window
    localparam logic [1:0] FILL_SEMIGRAPH = 2'd1;
    localparam logic [1:0] FILL_BLOCK     = 2'd3;

    // input operations
    localparam logic OP_RENDER     = 1'b0;
    localparam logic OP_FONT_WRITE = 1'b1;

    // how a cell is drawn
    typedef enum logic [2:0] {
        KIND_BG         = 3'd0,
        KIND_TEXT_BLANK = 3'd1,
        KIND_TEXT_GLYPH = 3'd2,
        KIND_SEMI       = 3'd3,
        KIND_BLOCK      = 3'd4
    } cell_kind_t;

    // decoded render job
    typedef struct packed {
        cell_kind_t          kind;
        logic [BYTE_W-1:0]   cell_byte;
        logic                glyph_ok;
    } job_t;

    // one colour repeated over the eight pixels
    function automatic logic [PIX_W-1:0] fill_row(input logic [3:0] c);
        fill_row = {8{c}};
    endfunction

    // eight pixels from a bit pattern, bit 7 leftmost
    function automatic logic [PIX_W-1:0] glyph_row(input logic [7:0] bits,
                                                   input logic [3:0] fg,
                                                   input logic [3:0] bg);
        logic [PIX_W-1:0] r;
        r = '0;
        for (int k = 0; k < 8; k++) begin
            r[PIX_W-1-4*k -: 4] = bits[7-k] ? fg : bg;
        end
        glyph_row = r;
    endfunction

endpackage

// ===== rtl/text_plane_cell_renderer.sv =====
// top level: cell decode, row sequencer over the font ram, output register
// A render transaction yields sixteen pixel rows, one per cycle while m_ready does
// not hold the output; the row sequencer reading the font ram sets this rate.
// The first row passes the job register and the read stage into the output register.
// A font write waits while a cell still reads glyph rows; no result.
// Synchronous active-low reset clears control state and the four registers;
// the font ram is not cleared and holds garbage until written.
module text_plane_cell_renderer
    import tpcr_pkg::*;
#(
    parameter int GLYPH_COUNT   = GLYPH_COUNT_DEF,
    parameter int PLANE_COLUMNS = PLANE_COLUMNS_DEF,
    parameter int PLANE_ROWS    = PLANE_ROWS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration write port
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    // input channel
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_opcode,
    input  logic [COL_W-1:0]      s_cell_col,
    input  logic [ROW_W-1:0]      s_cell_row,
    input  logic [BYTE_W-1:0]     s_cell_byte,
    input  logic [CODE_W-1:0]     s_glyph_code,
    input  logic [GLINE_W-1:0]    s_glyph_line,
    input  logic [7:0]            s_glyph_bits,
    // result channel
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [LINE_W-1:0]     m_pixel_line,
    output logic [PIX_W-1:0]      m_pixel_colors,
    output logic                  m_last_line
);

    localparam int FONT_DEPTH = GLYPH_COUNT * 8;
    localparam int ADDR_W     = $clog2(FONT_DEPTH);
    localparam int GCODE_W    = $clog2(GLYPH_COUNT);
    localparam int CW_RAW     = $clog2(PLANE_COLUMNS + 1);
    localparam int CW         = (CW_RAW > 5) ? CW_RAW : 5;
    localparam int RW_RAW     = $clog2(PLANE_ROWS + 1);
    localparam int RW         = (RW_RAW > 4) ? RW_RAW : 4;
    localparam logic [LINE_W-1:0] LAST_LINE = '1;

    // configuration registers
    logic [7:0] mode_control_reg;
    logic [7:0] color_control_reg;
    logic [7:0] window_limits_reg;
    logic [7:0] text_colors_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_control_reg  <= '0;
            color_control_reg <= '0;
            window_limits_reg <= '0;
            text_colors_reg   <= '0;
        end else if (cfg_we) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_MODE_CONTROL:  mode_control_reg  <= cfg_wdata;
                REG_COLOR_CONTROL: color_control_reg <= cfg_wdata;
                REG_WINDOW_LIMITS: window_limits_reg <= cfg_wdata;
                REG_TEXT_COLORS:   text_colors_reg   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // pipeline state
    logic                 job_valid_reg, job_valid_next;
    job_t                 job_reg;
    logic [LINE_W-1:0]    line_reg, line_next;
    logic                 b_valid_reg, b_valid_next;
    job_t                 b_job_reg;
    logic [LINE_W-1:0]    b_line_reg;
    logic                 m_valid_reg, m_valid_next;
    logic [LINE_W-1:0]    m_pixel_line_reg;
    logic [PIX_W-1:0]     m_pixel_colors_reg;
    logic                 m_last_line_reg;

    // handshake and flow control
    logic out_free;
    logic b_fire;
    logic b_free;
    logic issue;
    logic line_last;
    logic accept;
    logic render_accept;
    logic write_accept;

    assign out_free  = !m_valid_reg || m_ready;
    assign b_fire    = b_valid_reg && out_free;
    assign b_free    = !b_valid_reg || out_free;
    assign issue     = job_valid_reg && b_free;
    assign line_last = (line_reg == LAST_LINE);

    // a font write waits until the current job has no glyph row reads left
    assign s_ready = !job_valid_reg || (issue && line_last)
                   || ((s_opcode == OP_FONT_WRITE) && line_reg[3]);
    assign accept        = s_valid && s_ready;
    assign render_accept = accept && (s_opcode == OP_RENDER);
    assign write_accept  = accept && (s_opcode == OP_FONT_WRITE);

    // cell decode at acceptance
    logic [CW-1:0]          col_ext, xmax, xs, xe;
    logic [RW-1:0]          row_ext, ymax, ys, ye;
    logic                   visible, in_window;
    logic [CODE_W-1:0]      text_code;
    logic [CODE_EXT_W-1:0]  code_ext;
    job_t                   job_new;

    assign col_ext = CW'(s_cell_col);
    assign row_ext = RW'(s_cell_row);
    assign xmax    = CW'({window_limits_reg[3:0], 1'b0});
    assign ymax    = RW'(window_limits_reg[7:4]);
    assign xs      = mode_control_reg[6] ? xmax : '0;
    assign xe      = mode_control_reg[6] ? CW'(PLANE_COLUMNS) : xmax;
    assign ys      = mode_control_reg[7] ? ymax : '0;
    assign ye      = mode_control_reg[7] ? RW'(PLANE_ROWS) : ymax;

    assign visible   = (s_cell_col >= COL_W'(VIS_COL_MIN)) && (s_cell_col < COL_W'(VIS_COL_END))
                     && (s_cell_row >= ROW_W'(VIS_ROW_MIN));
    assign in_window = (ys <= row_ext) && (row_ext < ye) && (xs <= col_ext) && (col_ext < xe);
    assign text_code = (s_cell_col < COL_W'(TEXT_COL_END)) ? s_cell_byte[CODE_W-1:0] : '0;
    assign code_ext  = CODE_EXT_W'(text_code);

    always_comb begin
        job_new.cell_byte = s_cell_byte;
        job_new.glyph_ok  = (code_ext < CODE_EXT_W'(GLYPH_COUNT));
        priority if (!visible) begin
            job_new.kind = KIND_BG;
        end else if (in_window) begin
            job_new.kind = (text_code == '0) ? KIND_TEXT_BLANK : KIND_TEXT_GLYPH;
        end else if (mode_control_reg[1:0] == FILL_SEMIGRAPH) begin
            job_new.kind = KIND_SEMI;
        end else if (mode_control_reg[1:0] == FILL_BLOCK) begin
            job_new.kind = KIND_BLOCK;
        end else begin
            job_new.kind = KIND_BG;
        end
    end

    // font ram ports
    logic [CODE_EXT_W-1:0] wcode_ext;
    logic [CODE_EXT_W-1:0] rcode_ext;
    logic                  ram_we;
    logic [ADDR_W-1:0]     ram_waddr;
    logic [ADDR_W-1:0]     ram_raddr;
    logic [7:0]            ram_rdata;

    assign wcode_ext = CODE_EXT_W'(s_glyph_code);
    assign rcode_ext = CODE_EXT_W'(job_reg.cell_byte[CODE_W-1:0]);
    assign ram_we    = write_accept && (wcode_ext < CODE_EXT_W'(GLYPH_COUNT));
    assign ram_waddr = {wcode_ext[GCODE_W-1:0], s_glyph_line};
    assign ram_raddr = {rcode_ext[GCODE_W-1:0], line_reg[GLINE_W-1:0]};

    tpcr_ram #(
        .WIDTH (8),
        .DEPTH (FONT_DEPTH)
    ) u_font_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (s_glyph_bits),
        .re    (issue),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // row sequencer control
    always_comb begin
        job_valid_next = job_valid_reg;
        line_next      = line_reg;
        if (issue) begin
            line_next = line_reg + 1'b1;
            if (line_last) begin
                job_valid_next = 1'b0;
            end
        end
        if (render_accept) begin
            job_valid_next = 1'b1;
            line_next      = '0;
        end
        b_valid_next = issue ? 1'b1 : (b_fire ? 1'b0 : b_valid_reg);
        m_valid_next = b_fire ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            job_valid_reg <= 1'b0;
            line_reg      <= '0;
            b_valid_reg   <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            job_valid_reg <= job_valid_next;
            line_reg      <= line_next;
            b_valid_reg   <= b_valid_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // payload registers
    logic [PIX_W-1:0] row_colors;

    always_ff @(posedge aclk) begin
        if (render_accept) begin
            job_reg <= job_new;
        end
        if (issue) begin
            b_job_reg  <= job_reg;
            b_line_reg <= line_reg;
        end
        if (b_fire) begin
            m_pixel_line_reg   <= b_line_reg;
            m_pixel_colors_reg <= row_colors;
            m_last_line_reg    <= (b_line_reg == LAST_LINE);
        end
    end

    // row composition from font data
    tpcr_pixel_gen u_pixel_gen (
        .job           (b_job_reg),
        .line          (b_line_reg),
        .font_bits     (ram_rdata),
        .color_control (color_control_reg),
        .text_colors   (text_colors_reg),
        .pixel_colors  (row_colors)
    );

    assign m_valid        = m_valid_reg;
    assign m_pixel_line   = m_pixel_line_reg;
    assign m_pixel_colors = m_pixel_colors_reg;
    assign m_last_line    = m_last_line_reg;

`ifndef SYNTH
    // no font write while the running job still reads glyph rows
    a_no_write_during_reads: assert property (@(posedge aclk) disable iff (!aresetn)
        (job_valid_reg && !line_reg[3]) |-> !ram_we)
        else $error("font write overlaps glyph reads");

    // a render transaction while busy only when the last row issues
    a_render_handoff: assert property (@(posedge aclk) disable iff (!aresetn)
        (render_accept && job_valid_reg) |-> (issue && line_last))
        else $error("render accepted over a running job");

    // after the last row the sequencer is idle or restarts at row zero
    a_line_wrap: assert property (@(posedge aclk) disable iff (!aresetn)
        (issue && line_last) |=> (!job_valid_reg || line_reg == '0))
        else $error("row sequencer did not restart");

    // the read stage only advances into a free output register
    a_stage_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (b_valid_reg && m_valid_reg && !m_ready) |=> (b_valid_reg && $stable(b_line_reg)))
        else $error("read stage lost a row under backpressure");
`endif

endmodule

// ===== rtl/tpcr_ram.sv =====
// generic single write port, single read port ram with registered read
module tpcr_ram
    import tpcr_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // read port, output holds while no read is issued
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/tpcr_pixel_gen.sv =====
// builds one pixel row of a cell from the job, the row number and font data
module tpcr_pixel_gen
    import tpcr_pkg::*;
(
    input  job_t               job,
    input  logic [LINE_W-1:0]  line,
    input  logic [7:0]         font_bits,
    input  logic [7:0]         color_control,
    input  logic [7:0]         text_colors,
    output logic [PIX_W-1:0]   pixel_colors
);

    logic [3:0] bg;
    logic [3:0] cg;
    logic [3:0] fg;
    logic [3:0] tb;
    logic [3:0] cu;
    logic [3:0] cl;
    logic [1:0] quad;
    logic [7:0] semi_bits;

    assign bg   = color_control[3:0];
    assign cg   = color_control[7:4];
    assign fg   = text_colors[7:4];
    assign tb   = text_colors[3:0];
    assign cu   = job.cell_byte[7:4];
    assign cl   = job.cell_byte[3:0];
    assign quad = line[3:2];

    // quadrant pair for this group of four rows
    assign semi_bits = {{4{job.cell_byte[{~quad, 1'b1}]}}, {4{job.cell_byte[{~quad, 1'b0}]}}};

    // row select by cell kind
    always_comb begin
        unique case (job.kind)
            KIND_BG:         pixel_colors = fill_row(bg);
            KIND_TEXT_BLANK: pixel_colors = fill_row(tb);
            KIND_TEXT_GLYPH: pixel_colors = line[3] ? fill_row(tb)
                                          : glyph_row(job.glyph_ok ? font_bits : 8'h00, fg, tb);
            KIND_SEMI:       pixel_colors = glyph_row(semi_bits, cg, bg);
            KIND_BLOCK:      pixel_colors = line[3] ? fill_row((cl != 4'h0) ? cl : bg)
                                          : fill_row((cu != 4'h0) ? cu : bg);
            default:         pixel_colors = fill_row(bg);
        endcase
    end

endmodule
